// ===== hw/rtl/rpd_pkg.sv =====
`timescale 1ns / 1ps
package rpd_pkg;

  localparam int BUTTON_COUNT_DEF = 8;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_DEADBAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT    = 3'd4;

  // Configuration reset values
  localparam logic [31:0] SYNC_WORD_RST     = 32'hFFFF_0000;
  localparam logic [7:0]  DUTY_FLOOR_RST    = 8'd10;
  localparam logic [7:0]  DUTY_CEILING_RST  = 8'd127;
  localparam logic [6:0]  TURN_DEADBAND_RST = 7'd1;
  localparam logic [6:0]  TURN_LIMIT_RST    = 7'd60;

  // Packet type codes
  localparam logic [7:0] KIND_NONE         = 8'd0;
  localparam logic [7:0] KIND_DUTY         = 8'd1;
  localparam logic [7:0] KIND_HEADING      = 8'd2;
  localparam logic [7:0] KIND_TURN         = 8'd3;
  localparam logic [7:0] KIND_BUTTON_FIRST = 8'd4;
  localparam logic [7:0] KIND_BUTTON_LAST  = 8'd11;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]  kind;
    logic [15:0] raw;
  } pkt_t;

  typedef struct packed {
    logic [7:0] duty_floor;
    logic [7:0] duty_ceiling;
    logic [6:0] turn_deadband;
    logic [6:0] turn_limit;
  } cfg_t;

endpackage

// ===== hw/rtl/rpd_if.sv =====
`timescale 1ns / 1ps
interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rpd_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         duty;
  logic signed [15:0] heading;
  logic signed [7:0]  turn_rate;
  logic [3:0]         last_command;
  logic [7:0]         packet_kind;
  logic signed [15:0] packet_value;

  modport source (output valid, output duty, output heading, output turn_rate,
                  output last_command, output packet_kind, output packet_value,
                  input ready);
  modport sink (input valid, input duty, input heading, input turn_rate,
                input last_command, input packet_kind, input packet_value,
                output ready);
endinterface

interface rpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rpd_front.sv =====
`timescale 1ns / 1ps
module rpd_front
  import rpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rpd_in_if.sink      rx,
  input  logic [31:0] sync_word,
  input  logic        q_full,
  output logic        push,
  output pkt_t        push_pkt
);

  logic [7:0] sync_window [4];
  logic [2:0] fill_count;
  logic [7:0] pending_kind;
  logic       high_seen;
  logic [7:0] value_high;
  logic       take;
  logic       filled;
  logic       locked;

  assign rx.ready = !q_full;
  assign take     = rx.valid && rx.ready;
  assign filled   = fill_count[2];
  assign locked   = {sync_window[0], sync_window[1], sync_window[2], sync_window[3]}
                    == sync_word;

  assign push          = take && filled && locked && (pending_kind != KIND_NONE)
                         && high_seen;
  assign push_pkt.kind = pending_kind;
  assign push_pkt.raw  = {value_high, rx.rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) sync_window[i] <= '0;
      fill_count   <= '0;
      pending_kind <= KIND_NONE;
      high_seen    <= 1'b0;
      value_high   <= '0;
    end else if (take) begin
      if (!filled) begin
        sync_window[fill_count[1:0]] <= rx.rx_byte;
        fill_count <= fill_count + 3'd1;
      end else if (!locked) begin
        // slide the window by one byte
        sync_window[0] <= sync_window[1];
        sync_window[1] <= sync_window[2];
        sync_window[2] <= sync_window[3];
        sync_window[3] <= rx.rx_byte;
      end else if (pending_kind == KIND_NONE) begin
        pending_kind <= rx.rx_byte;
      end else if (!high_seen) begin
        value_high <= rx.rx_byte;
        high_seen  <= 1'b1;
      end else begin
        fill_count   <= '0;
        pending_kind <= KIND_NONE;
        high_seen    <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/rpd_queue.sv =====
`timescale 1ns / 1ps
module rpd_queue
  import rpd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_pkt,
  output logic full,
  output logic not_empty,
  input  logic pop,
  output pkt_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pkt_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_pkt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rpd_back.sv =====
`timescale 1ns / 1ps
module rpd_back
  import rpd_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     head_valid,
  input  pkt_t     head,
  output logic     pop,
  rpd_out_if.source res
);

  localparam int BIDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  logic [7:0]         duty_reg;
  logic [15:0]        heading_reg;
  logic signed [7:0]  turn_reg;
  logic [3:0]         command_reg;
  logic [15:0]        button_store [BUTTON_COUNT];

  logic [7:0]         duty_next;
  logic [15:0]        heading_next;
  logic signed [7:0]  turn_next;
  logic [3:0]         command_next;
  logic signed [16:0] v;
  logic signed [16:0] floor_s;
  logic signed [16:0] ceil_s;
  logic signed [16:0] db_s;
  logic signed [16:0] lim_s;
  logic signed [16:0] t_dead;
  logic signed [16:0] t_sat;
  logic               is_button;
  logic [7:0]         btn_off;
  logic               btn_write;

  assign pop = head_valid && (!res.valid || res.ready);

  assign v       = {head.raw[15], head.raw};
  assign floor_s = {9'b0, cfg.duty_floor};
  assign ceil_s  = {9'b0, cfg.duty_ceiling};
  assign db_s    = {10'b0, cfg.turn_deadband};
  assign lim_s   = {10'b0, cfg.turn_limit};

  assign is_button = (head.kind >= KIND_BUTTON_FIRST) && (head.kind <= KIND_BUTTON_LAST);
  assign btn_off   = head.kind - KIND_BUTTON_FIRST;
  assign btn_write = is_button && (btn_off < 8'(BUTTON_COUNT));

  // dead band first, then saturate
  always_comb begin
    t_dead = ((v <= db_s) && (v >= -db_s)) ? 17'sd0 : v;
    if (t_dead > lim_s)       t_sat = lim_s;
    else if (t_dead < -lim_s) t_sat = -lim_s;
    else                      t_sat = t_dead;
  end

  always_comb begin
    duty_next    = duty_reg;
    heading_next = heading_reg;
    turn_next    = turn_reg;
    command_next = command_reg;
    if (head.kind == KIND_DUTY) begin
      if (v < floor_s)     duty_next = '0;
      else if (v > ceil_s) duty_next = cfg.duty_ceiling;
      else                 duty_next = v[7:0];
    end else if (head.kind == KIND_HEADING) begin
      heading_next = head.raw;
    end else if (head.kind == KIND_TURN) begin
      turn_next = t_sat[7:0];
    end else if (is_button) begin
      command_next = head.kind[3:0];
    end
    if (duty_next < cfg.duty_floor) heading_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_reg    <= '0;
      heading_reg <= '0;
      turn_reg    <= '0;
      command_reg <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) button_store[i] <= '0;
    end else if (pop) begin
      duty_reg    <= duty_next;
      heading_reg <= heading_next;
      turn_reg    <= turn_next;
      command_reg <= command_next;
      if (btn_write) button_store[btn_off[BIDX_W-1:0]] <= head.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.duty         <= duty_next;
      res.heading      <= heading_next;
      res.turn_rate    <= turn_next;
      res.last_command <= command_next;
      res.packet_kind  <= head.kind;
      res.packet_value <= head.raw;
    end
  end

endmodule

// ===== hw/rtl/remote_packet_deframer_core.sv =====
`timescale 1ns / 1ps
// Each packet is queued when its low byte is taken, then popped into the output register.
// Throughput: at most one result per cycle, set by the output register; one byte per cycle
// unless the front stalls, which it does only when the two-entry packet queue is full.
// Reset (rst, synchronous, active high): framing, packet state, queue, output valid cleared;
// configuration returns to its defaults. No clearing pass is needed.
module remote_packet_deframer_core
  import rpd_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rpd_in_if.sink    rx,
  rpd_out_if.source res,
  rpd_cfg_if.sink   cfg
);

  // Configuration registers
  logic [31:0] sync_word;
  cfg_t        cfg_regs;

  // Front-to-queue and queue-to-back signals
  logic push;
  pkt_t push_pkt;
  logic q_full;
  logic q_not_empty;
  logic pop;
  pkt_t head;

  // Always take configuration writes; they must arrive only while the block is idle (not enforced here).
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word              <= SYNC_WORD_RST;
      cfg_regs.duty_floor    <= DUTY_FLOOR_RST;
      cfg_regs.duty_ceiling  <= DUTY_CEILING_RST;
      cfg_regs.turn_deadband <= TURN_DEADBAND_RST;
      cfg_regs.turn_limit    <= TURN_LIMIT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SYNC_WORD:     sync_word              <= cfg.data;
        REG_DUTY_FLOOR:    cfg_regs.duty_floor    <= cfg.data[7:0];
        REG_DUTY_CEILING:  cfg_regs.duty_ceiling  <= cfg.data[7:0];
        REG_TURN_DEADBAND: cfg_regs.turn_deadband <= cfg.data[6:0];
        REG_TURN_LIMIT:    cfg_regs.turn_limit    <= cfg.data[6:0];
        default:           ; // drop writes to unknown indexes
      endcase
    end
  end

  // Front: hunt for the sync word, collect type and value bytes, hand off packets.
  rpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .sync_word(sync_word),
    .q_full   (q_full),
    .push     (push),
    .push_pkt (push_pkt)
  );

  // Short queue that decouples framing from packet execution.
  rpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (q_full),
    .not_empty(q_not_empty),
    .pop      (pop),
    .head     (head)
  );

  // Back: apply each packet to the control registers and register the result.
  rpd_back #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .head_valid(q_not_empty),
    .head      (head),
    .pop       (pop),
    .res       (res)
  );

  // A completed packet never arrives at a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("packet pushed into full queue");

  // Heading reads zero whenever the reported duty is below the floor.
  a_heading_gated: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.duty >= cfg_regs.duty_floor) || (res.heading == 16'sd0))
    else $error("heading not forced to zero below duty floor");

  // A pop needs a queued packet.
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_not_empty)
    else $error("pop from empty queue");

  // No result is presented right after reset.
  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid after reset");

endmodule

// ===== bench/tb_remote_packet_deframer_core.sv =====
`timescale 1ns / 1ps
import rpd_pkg::*;

// One completed packet as it leaves the block.
typedef struct {
  logic [7:0]         duty;
  logic signed [15:0] heading;
  logic signed [7:0]  turn_rate;
  logic [3:0]         last_command;
  logic [7:0]         packet_kind;
  logic signed [15:0] packet_value;
} packet_report_t;

class deframer_scoreboard;
  // Register copies.
  logic [31:0] sync_word;
  logic [7:0]  duty_floor;
  logic [7:0]  duty_ceiling;
  logic [6:0]  turn_deadband;
  logic [6:0]  turn_limit;

  // Framing state.
  logic [7:0]  window [4];
  int unsigned fill_count;
  logic [7:0]  kind_held;
  bit          high_seen;
  logic [7:0]  value_high;

  // Control state that shows up in every report.
  logic [7:0]         duty;
  logic signed [15:0] heading;
  logic signed [7:0]  turn;
  logic [3:0]         command;

  packet_report_t expected_reports [$];
  int mismatches;

  function new();
    sync_word     = SYNC_WORD_RST;
    duty_floor    = DUTY_FLOOR_RST;
    duty_ceiling  = DUTY_CEILING_RST;
    turn_deadband = TURN_DEADBAND_RST;
    turn_limit    = TURN_LIMIT_RST;
    foreach (window[i]) window[i] = 8'h00;
    fill_count = 0;
    kind_held  = KIND_NONE;
    high_seen  = 0;
    value_high = 8'h00;
    duty       = 8'h00;
    heading    = 16'sh0000;
    turn       = 8'sh00;
    command    = 4'h0;
    mismatches = 0;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SYNC_WORD:     sync_word = data;
      REG_DUTY_FLOOR:    duty_floor = data[7:0];
      REG_DUTY_CEILING:  duty_ceiling = data[7:0];
      REG_TURN_DEADBAND: turn_deadband = data[6:0];
      REG_TURN_LIMIT:    turn_limit = data[6:0];
      default: ;
    endcase
  endfunction

  // Advance the framer by one accepted byte; queue a report when a packet completes.
  function void note_byte(logic [7:0] b);
    logic [15:0]    raw;
    int             v;
    packet_report_t rep;
    if (fill_count < 4) begin
      window[fill_count] = b;
      fill_count++;
      return;
    end
    if ({window[0], window[1], window[2], window[3]} != sync_word) begin
      window[0] = window[1];
      window[1] = window[2];
      window[2] = window[3];
      window[3] = b;
      return;
    end
    if (kind_held == KIND_NONE) begin
      kind_held = b;
      return;
    end
    if (!high_seen) begin
      value_high = b;
      high_seen  = 1;
      return;
    end
    raw = {value_high, b};
    v   = int'($signed(raw));
    if (kind_held == KIND_DUTY) begin
      if (v < int'(duty_floor)) duty = 8'h00;
      else if (v > int'(duty_ceiling)) duty = duty_ceiling;
      else duty = v[7:0];
    end else if (kind_held == KIND_HEADING) begin
      heading = raw;
    end else if (kind_held == KIND_TURN) begin
      // Dead band first, then saturation, so a wide band beats a narrow limit.
      if (v <= int'(turn_deadband) && v >= -int'(turn_deadband)) v = 0;
      if (v > int'(turn_limit)) v = int'(turn_limit);
      if (v < -int'(turn_limit)) v = -int'(turn_limit);
      turn = v[7:0];
    end else if (kind_held >= KIND_BUTTON_FIRST && kind_held <= KIND_BUTTON_LAST) begin
      // Button values are stored inside and reported only as the packet value; the command shows too.
      command = kind_held[3:0];
    end
    if (duty < duty_floor) heading = 16'sh0000;
    rep.duty         = duty;
    rep.heading      = heading;
    rep.turn_rate    = turn;
    rep.last_command = command;
    rep.packet_kind  = kind_held;
    rep.packet_value = raw;
    expected_reports.push_back(rep);
    fill_count = 0;
    kind_held  = KIND_NONE;
    high_seen  = 0;
  endfunction

  function void check_result(packet_report_t got);
    packet_report_t want;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result kind=%0d value=%0d", $realtime, got.packet_kind,
                 got.packet_value);
      return;
    end
    want = expected_reports.pop_front();
    if (got.duty !== want.duty || got.heading !== want.heading ||
        got.turn_rate !== want.turn_rate || got.last_command !== want.last_command ||
        got.packet_kind !== want.packet_kind || got.packet_value !== want.packet_value) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch expected duty=%0d heading=%0d turn=%0d cmd=%0d kind=%0d value=%0d",
                 $realtime, want.duty, want.heading, want.turn_rate, want.last_command,
                 want.packet_kind, want.packet_value);
        $display("%0t:          actual duty=%0d heading=%0d turn=%0d cmd=%0d kind=%0d value=%0d",
                 $realtime, got.duty, got.heading, got.turn_rate, got.last_command,
                 got.packet_kind, got.packet_value);
      end
    end
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction
endclass

module tb_remote_packet_deframer_core;

  // Cycles with no request moving on any channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Cycles to let the packet queue and output register settle before a register write.
  localparam int SETTLE_CYCLES = 8;
  // Index past the register file; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  logic clk = 1'b0;
  logic rst;

  rpd_in_if  rx_if ();
  rpd_out_if res_if ();
  rpd_cfg_if cfg_if ();

  remote_packet_deframer_core u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  always #5 clk = ~clk;

  deframer_scoreboard sb = new();

  // Settings the stimulus aims at; the scoreboard keeps its own copy from the write channel.
  logic [31:0] cur_sync;
  logic [7:0]  cur_floor;
  logic [7:0]  cur_ceiling;
  logic [6:0]  cur_deadband;
  logic [6:0]  cur_limit;

  bit calm = 1'b0;      // hold both sides busy with no idling while set
  int bytes_sent = 0;
  int idle_cycles = 0;

  // Receiver: drop ready about a third of the time unless in a calm stretch.
  always begin
    res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
    @(posedge clk);
  end

  // Monitor every channel on the edge and feed the scoreboard.
  always @(posedge clk) begin
    packet_report_t got;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_register(cfg_if.index, cfg_if.data);
      if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte);
      if (res_if.valid && res_if.ready) begin
        got.duty         = res_if.duty;
        got.heading      = res_if.heading;
        got.turn_rate    = res_if.turn_rate;
        got.last_command = res_if.last_command;
        got.packet_kind  = res_if.packet_kind;
        got.packet_value = res_if.packet_value;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: count cycles in which no request is accepted anywhere.
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("remote_packet_deframer_core regression: fail");
        $finish;
      end
    end
  end

  // Offer one byte, idling first at random, and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 33) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
  endtask

  task automatic send_sync();
    send_byte(cur_sync[31:24]);
    send_byte(cur_sync[23:16]);
    send_byte(cur_sync[15:8]);
    send_byte(cur_sync[7:0]);
  endtask

  // Sync word, optional zero type bytes, type, value high, value low.
  task automatic send_packet(input logic [7:0] kind, input logic [15:0] value, input int zeros);
    send_sync();
    repeat (zeros) send_byte(KIND_NONE);
    send_byte(kind);
    send_byte(value[15:8]);
    send_byte(value[7:0]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Write every register back to back, then drop valid once.
  task automatic configure(input logic [31:0] sync, input logic [7:0] floor_v,
                           input logic [7:0] ceil_v, input logic [6:0] band_v,
                           input logic [6:0] lim_v, input bit poke_unused);
    write_reg(REG_SYNC_WORD, sync);
    write_reg(REG_DUTY_FLOOR, {24'h0, floor_v});
    write_reg(REG_DUTY_CEILING, {24'h0, ceil_v});
    write_reg(REG_TURN_DEADBAND, {25'h0, band_v});
    write_reg(REG_TURN_LIMIT, {25'h0, lim_v});
    if (poke_unused) write_reg(REG_UNUSED, $urandom);
    cfg_if.valid <= 1'b0;
    cur_sync     = sync;
    cur_floor    = floor_v;
    cur_ceiling  = ceil_v;
    cur_deadband = band_v;
    cur_limit    = lim_v;
  endtask

  // Wait for every expected report, then let any queued work settle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_kind();
    int r;
    r = $urandom_range(19);
    if (r <= 10) return 8'(r + 1);
    if (r == 11) return KIND_DUTY;
    if (r == 12) return KIND_HEADING;
    if (r == 13) return KIND_TURN;
    return 8'($urandom_range(255, int'(KIND_BUTTON_LAST) + 1));
  endfunction

  // Bias values toward the edges of the clamps under the current settings.
  function automatic logic [15:0] pick_value();
    int r;
    int v;
    r = $urandom_range(11);
    case (r)
      0: v = 32'h7FFF;
      1: v = -32768;
      2: v = 0;
      3: v = -1;
      4: v = int'(cur_floor) + $urandom_range(2) - 1;
      5: v = int'(cur_ceiling) + $urandom_range(2) - 1;
      6: v = int'(cur_deadband) + $urandom_range(2) - 1;
      7: v = -(int'(cur_deadband) + $urandom_range(2) - 1);
      8: v = int'(cur_limit) + $urandom_range(2) - 1;
      9: v = -(int'(cur_limit) + $urandom_range(2) - 1);
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  // Mostly well-formed packets with random content; the rest noise or cut-off packets.
  task automatic run_phase(input int n_bytes);
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_packet(pick_kind(), pick_value(), ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        // Cut a packet short; the following bytes get read as its remainder.
        send_sync();
        send_byte(pick_kind());
      end
    end
    rx_if.valid <= 1'b0;
    drain();
  endtask

  initial begin
    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= REG_SYNC_WORD;
    cfg_if.data   <= '0;
    cur_sync     = SYNC_WORD_RST;
    cur_floor    = DUTY_FLOOR_RST;
    cur_ceiling  = DUTY_CEILING_RST;
    cur_deadband = TURN_DEADBAND_RST;
    cur_limit    = TURN_LIMIT_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass on reset settings: a stray byte so the window has to slide,
    // full-scale duty, a zero type byte ahead of the most negative heading,
    // and a turn of -1 that falls into the dead band.
    send_byte(8'h5A);
    send_packet(KIND_DUTY, 16'h7FFF, 0);
    send_packet(KIND_HEADING, 16'h8000, 1);
    send_packet(KIND_TURN, 16'hFFFF, 0);
    rx_if.valid <= 1'b0;
    drain();

    // Widest clamps, no dead band.
    configure($urandom, 8'd0, 8'd255, 7'd0, 7'd127, 1'b0);
    run_phase(320);

    // Floor above ceiling and dead band above limit; poke an unused index too.
    configure(32'hFFFF_FFFF, 8'd255, 8'd0, 7'd127, 7'd0, 1'b1);
    run_phase(320);

    configure(32'h0000_0000, 8'd50, 8'd200, 7'd10, 7'd100, 1'b0);
    run_phase(320);

    // Long stretch with both sides always ready.
    calm = 1'b1;
    configure($urandom, 8'($urandom), 8'($urandom), 7'($urandom), 7'($urandom), 1'b0);
    run_phase(320);
    calm = 1'b0;

    configure($urandom, 8'($urandom), 8'($urandom), 7'($urandom), 7'($urandom), 1'b0);
    run_phase(320);

    configure(SYNC_WORD_RST, DUTY_FLOOR_RST, DUTY_CEILING_RST, TURN_DEADBAND_RST,
              TURN_LIMIT_RST, 1'b0);
    run_phase(320);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("remote_packet_deframer_core regression: pass");
    else
      $display("remote_packet_deframer_core regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rpd_pkg.sv
hw/rtl/rpd_if.sv
hw/rtl/rpd_front.sv
hw/rtl/rpd_queue.sv
hw/rtl/rpd_back.sv
hw/rtl/remote_packet_deframer_core.sv
bench/tb_remote_packet_deframer_core.sv
